// ----- hw/rtl/fmr_pkg.sv -----
// Shared constants, register codes and control structs for the first-match replace stream.
package fmr_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned REPLACE_MAX = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned REG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned BYTES_W     = 2 * REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW      = 3'd0,
    CFG_PATTERN_HIGH     = 3'd1,
    CFG_PATTERN_LENGTH   = 3'd2,
    CFG_REPLACEMENT_LOW  = 3'd3,
    CFG_REPLACEMENT_HIGH = 3'd4,
    CFG_REPLACEMENT_LEN  = 3'd5
  } cfg_reg_e;

  // Per-cell control: load the new character, or take the right neighbor's byte.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Window control: shift the whole row, and load the new character at one position.
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [POS_W-1:0] pos;
  } win_ctrl_t;

  // Words still owed for one accepted character, in emission order.
  typedef struct packed {
    logic [LEN_W-1:0]  rep_a;
    logic              single_v;
    logic [CHAR_W-1:0] single_ch;
    logic [LEN_W-1:0]  rep_b;
    logic [LEN_W-1:0]  flush;
    logic              empty_v;
    logic              last;
  } job_t;

  // Clamp a length register to its capacity.
  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] v, logic [LEN_W-1:0] cap);
    return (v > cap) ? cap : v;
  endfunction

endpackage

// ----- hw/rtl/fmr_cell.sv -----
// One window cell: holds a byte, takes the new character or its neighbor, compares to the pattern.
module fmr_cell import fmr_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic [CHAR_W-1:0] next_i,
  input  logic [CHAR_W-1:0] pat_i,
  output logic [CHAR_W-1:0] q_o,
  output logic              eq_o
);

  logic [CHAR_W-1:0] byte_d, byte_q;

  always_comb begin
    if (ctrl_i.load) begin
      byte_d = ch_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Compare the value this cell holds after the edge.
  assign eq_o = (byte_d == pat_i);
  assign q_o  = byte_q;

endmodule

// ----- hw/rtl/fmr_window.sv -----
// Row of window cells; entry 0 holds the oldest character and is the head of the row.
module fmr_window import fmr_pkg::*; (
  input  logic                   clk_i,
  input  win_ctrl_t              ctrl_i,
  input  logic [CHAR_W-1:0]      ch_i,
  input  logic [BYTES_W-1:0]     pattern_i,
  output logic [CHAR_W-1:0]      head_o,
  output logic [PATTERN_MAX-1:0] eq_o
);

  logic [CHAR_W-1:0] cell_q [PATTERN_MAX];

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    cell_ctrl_t        cctrl;
    logic [CHAR_W-1:0] nbr;

    assign cctrl.shift = ctrl_i.shift;
    assign cctrl.load  = ctrl_i.load && (ctrl_i.pos == POS_W'(k));

    if (k == PATTERN_MAX - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end

    fmr_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctrl),
      .ch_i   (ch_i),
      .next_i (nbr),
      .pat_i  (pattern_i[k*CHAR_W +: CHAR_W]),
      .q_o    (cell_q[k]),
      .eq_o   (eq_o[k])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ----- hw/rtl/fmr_seq.sv -----
// Output sequencer: walks the owed words of one character and drives the output register.
module fmr_seq import fmr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_load_i,
  input  job_t               job_i,
  input  logic [BYTES_W-1:0] rep_i,
  input  logic [CHAR_W-1:0]  head_i,
  output logic               flush_shift_o,
  output logic               job_free_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [CHAR_W-1:0]  m_axis_tdata_o, // out_char
  output logic               m_axis_tuser_o, // has_char
  output logic               m_axis_tlast_o  // out_last
);

  job_t              job_d, job_q, job_n;
  logic [POS_W-1:0]  idx_d, idx_q, idx_n;
  logic              go, busy, final_w;
  logic [CHAR_W-1:0] ch_w, rep_byte;
  logic              has_w;

  logic              vld_d, vld_q;
  logic [CHAR_W-1:0] chr_d, chr_q;
  logic              has_d, has_q, lst_d, lst_q;

  function automatic logic job_busy(job_t j);
    return (j.rep_a != '0) || j.single_v || (j.rep_b != '0) || (j.flush != '0) || j.empty_v;
  endfunction

  assign busy     = job_busy(job_q);
  assign go       = busy && (!vld_q || m_axis_tready_i);
  assign rep_byte = rep_i[idx_q*CHAR_W +: CHAR_W];

  always_comb begin
    job_n         = job_q;
    idx_n         = idx_q;
    ch_w          = '0;
    has_w         = 1'b0;
    flush_shift_o = 1'b0;
    if (go) begin
      if (job_q.rep_a != '0) begin
        ch_w       = rep_byte;
        has_w      = 1'b1;
        job_n.rep_a = job_q.rep_a - LEN_W'(1);
        idx_n      = idx_q + POS_W'(1);
      end else if (job_q.single_v) begin
        ch_w           = job_q.single_ch;
        has_w          = 1'b1;
        job_n.single_v = 1'b0;
      end else if (job_q.rep_b != '0) begin
        ch_w        = rep_byte;
        has_w       = 1'b1;
        job_n.rep_b = job_q.rep_b - LEN_W'(1);
        idx_n       = idx_q + POS_W'(1);
      end else if (job_q.flush != '0) begin
        ch_w          = head_i;
        has_w         = 1'b1;
        job_n.flush   = job_q.flush - LEN_W'(1);
        flush_shift_o = 1'b1;
      end else begin
        // empty end marker
        job_n.empty_v = 1'b0;
      end
    end
  end

  assign final_w    = go && !job_busy(job_n);
  assign job_free_o = !busy || final_w;

  always_comb begin
    if (job_load_i) begin
      job_d = job_i;
      idx_d = '0;
    end else begin
      job_d = job_n;
      idx_d = idx_n;
    end
  end

  always_comb begin
    vld_d = vld_q;
    chr_d = chr_q;
    has_d = has_q;
    lst_d = lst_q;
    if (go) begin
      vld_d = 1'b1;
      chr_d = ch_w;
      has_d = has_w;
      lst_d = job_q.last && final_w;
    end else if (m_axis_tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      job_q <= job_d;
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    has_q <= has_d;
    lst_q <= lst_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = chr_q;
  assign m_axis_tuser_o  = has_q;
  assign m_axis_tlast_o  = lst_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> job_free_o)
    else $error("job loaded while previous words still owed");

  a_one_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((job_q.rep_a != '0) && (job_q.rep_b != '0)))
    else $error("both replacement bursts pending");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_q.empty_v |-> (job_q.last && !job_q.single_v && (job_q.rep_a == '0) &&
                       (job_q.rep_b == '0) && (job_q.flush == '0)))
    else $error("end marker pending beside other words");
`endif

endmodule

// ----- hw/rtl/first_match_replace_stream.sv -----
// Top level: configuration registers, window update and match decision, output sequencing.
// A character's result words pass through the job register and then the output register.
// Throughput: one character per cycle while each character yields at most one word and the
// output is not stalled; a character yielding more words (replacement burst, final flush) holds the input.
// Reset: rst_ni clears control and config registers, window fill and match state at once; no clearing pass.
// Window bytes carry no reset: a byte is read only after it has been written.
module first_match_replace_stream import fmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  // text in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [CHAR_W-1:0]    s_axis_tdata_i,  // text_char
  input  logic                 s_axis_tlast_i,  // text_last
  // rewritten text out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [CHAR_W-1:0]    m_axis_tdata_o,  // out_char
  output logic                 m_axis_tuser_o,  // has_char
  output logic                 m_axis_tlast_o   // out_last
);

  // Configuration registers
  logic [REG_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LEN_W-1:0] pat_len_q, rep_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LOW:      pat_lo_q  <= cfg_wdata_i;
        CFG_PATTERN_HIGH:     pat_hi_q  <= cfg_wdata_i;
        CFG_PATTERN_LENGTH:   pat_len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_REPLACEMENT_LOW:  rep_lo_q  <= cfg_wdata_i;
        CFG_REPLACEMENT_HIGH: rep_hi_q  <= cfg_wdata_i;
        CFG_REPLACEMENT_LEN:  rep_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  logic [LEN_W-1:0] plen, rlen;
  assign plen = eff_len(pat_len_q, LEN_W'(PATTERN_MAX));
  assign rlen = eff_len(rep_len_q, LEN_W'(REPLACE_MAX));

  // Text state
  logic [LEN_W-1:0] fill_d, fill_q;
  logic             done_d, done_q;
  logic             started_d, started_q;

  logic                   in_acc, free, flush_shift;
  logic                   do_pre, md, pop, wr, hit;
  logic [LEN_W-1:0]       fill_pop, fill_w;
  logic [CHAR_W-1:0]      head;
  logic [PATTERN_MAX-1:0] eq_v, mask;
  win_ctrl_t              wctrl;
  job_t                   job;

  assign s_axis_tready_o = free;
  assign in_acc          = s_axis_tvalid_i && free;

  // Empty pattern: insert the replacement ahead of the first character.
  assign do_pre = !done_q && !started_q && (plen == '0);
  assign md     = done_q || do_pre;

  // Drop the oldest byte once the window reaches the pattern length.
  assign pop      = !md && (fill_q != '0) && (fill_q >= plen);
  assign fill_pop = fill_q - LEN_W'(pop);
  assign wr       = !md && (fill_pop < LEN_W'(PATTERN_MAX));
  assign fill_w   = fill_pop + LEN_W'(wr);

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      mask[k] = (LEN_W'(k) < plen);
    end
  end

  // Compare only when the window holds exactly the pattern length.
  assign hit = !md && (plen != '0) && (fill_w == plen) && (&(eq_v | ~mask));

  assign wctrl.shift = (in_acc && pop) || flush_shift;
  assign wctrl.load  = in_acc && wr;
  assign wctrl.pos   = fill_pop[POS_W-1:0];

  always_comb begin
    job.rep_a     = do_pre ? rlen : '0;
    job.single_v  = md || pop;
    job.single_ch = md ? s_axis_tdata_i : head;
    job.rep_b     = hit ? rlen : '0;
    job.flush     = (s_axis_tlast_i && !hit && !md) ? fill_w : '0;
    job.last      = s_axis_tlast_i;
    job.empty_v   = s_axis_tlast_i && !job.single_v && (job.rep_a == '0) &&
                    (job.rep_b == '0) && (job.flush == '0);
  end

  always_comb begin
    fill_d    = fill_q;
    done_d    = done_q;
    started_d = started_q;
    if (in_acc) begin
      if (s_axis_tlast_i) begin
        // end of text: start the next one fresh
        fill_d    = '0;
        done_d    = 1'b0;
        started_d = 1'b0;
      end else begin
        fill_d    = (md || hit) ? '0 : fill_w;
        done_d    = md || hit;
        started_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      done_q    <= 1'b0;
      started_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      done_q    <= done_d;
      started_q <= started_d;
    end
  end

  fmr_window u_window (
    .clk_i     (clk_i),
    .ctrl_i    (wctrl),
    .ch_i      (s_axis_tdata_i),
    .pattern_i ({pat_hi_q, pat_lo_q}),
    .head_o    (head),
    .eq_o      (eq_v)
  );

  fmr_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_load_i      (in_acc),
    .job_i           (job),
    .rep_i           ({rep_hi_q, rep_lo_q}),
    .head_i          (head),
    .flush_shift_o   (flush_shift),
    .job_free_o      (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(PATTERN_MAX))
    else $error("window fill beyond capacity");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (fill_q == '0))
    else $error("window still holds bytes after the match");

  a_done_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> started_q)
    else $error("match recorded outside a text");
`endif

endmodule
